@@ src/rmoh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmoh_pkg
// Shared types and constants of the ray marcher: field widths, opcodes,
// register indexes, controller states and the command / status bundles.
// ----------------------------------------------------------------------------
package rmoh_pkg;

    localparam int MAX_SQUARES_DEF = 64;
    localparam int MAX_CIRCLES_DEF = 64;

    localparam int POS_W      = 24;
    localparam int STEP_W     = 12;
    localparam int BS_W       = 10;
    localparam int CNT_W      = 7;
    localparam int COORD_W    = 16;
    localparam int ANG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 64;
    localparam int M_TUSER_W  = 1;

    // reset values of the registers
    localparam logic [POS_W-1:0]  VIEWER_RST = '0;
    localparam logic [STEP_W-1:0] MAX_STEPS_RST = 12'd1024;
    localparam logic [BS_W-1:0]   BLOCK_SIZE_RST = 10'd64;
    localparam logic [CNT_W-1:0]  COUNT_RST = '0;

    // quarter-wave sine polynomial
    localparam logic [16:0] SIN_C1    = 17'd42334;
    localparam logic [16:0] SIN_C2    = 17'd5223;
    localparam logic [16:0] SIN_C3    = 17'd102944;
    localparam logic [16:0] Q15_MAX   = 17'd32767;
    localparam logic [15:0] QUARTER   = 16'd16384;
    localparam logic [1:0]  TRIG_LAST = 2'd3;

    typedef enum logic [1:0] {
        OP_WR_SQUARE = 2'd0,
        OP_WR_CIRCLE = 2'd1,
        OP_CAST      = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEWER_X     = 3'd0,
        CFG_VIEWER_Y     = 3'd1,
        CFG_MAX_STEPS    = 3'd2,
        CFG_BLOCK_SIZE   = 3'd3,
        CFG_SQUARE_COUNT = 3'd4,
        CFG_CIRCLE_COUNT = 3'd5
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TRIG = 5'b00010,
        ST_STEP = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    typedef struct packed {
        logic accept;       // input transfer this cycle
        logic load;         // start of a cast
        logic trig_run;     // advance sine / cosine sequence
        logic step_pt;      // form point of current depth
        logic scan_run;     // walk the obstacle tables
        logic next_step;    // advance depth
        logic result_load;  // fill output register
    } cmd_t;

    typedef struct packed {
        logic trig_done;
        logic scan_done;
        logic pipe_busy;
        logic hit;
        logic last_step;
        logic zero_steps;
        logic out_free;
    } sts_t;

endpackage : rmoh_pkg
`default_nettype wire

@@ src/rmoh_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmoh_ctrl
// Sequencer of a cast: sine / cosine, then per depth step a point and a
// table scan, then the result hand-off.
// ----------------------------------------------------------------------------
module rmoh_ctrl
    import rmoh_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      s_tready,
    input  wire sts_t                 sts,
    output cmd_t                      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (s_tuser == OP_CAST) begin
                        cmd.load   = 1'b1;
                        state_next = ST_TRIG;
                    end
                end
            end
            ST_TRIG: begin
                cmd.trig_run = 1'b1;
                if (sts.trig_done) begin
                    state_next = sts.zero_steps ? ST_DONE : ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.step_pt = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done && !sts.pipe_busy) begin
                    if (sts.hit || sts.last_step) begin
                        state_next = ST_DONE;
                    end else begin
                        cmd.next_step = 1'b1;
                        state_next    = ST_STEP;
                    end
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_scan_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && sts.scan_done && !sts.pipe_busy)
        |=> (state_reg == ST_DONE || state_reg == ST_STEP))
        else $error("scan end did not leave scan state");

    a_trig_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TRIG && sts.trig_done && !sts.zero_steps)
        |=> (state_reg == ST_STEP))
        else $error("trig end did not start a step");

    a_done_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load |=> (state_reg == ST_IDLE))
        else $error("result load did not return to idle");

endmodule : rmoh_ctrl
`default_nettype wire

@@ src/rmoh_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmoh_dpath
// Registers, obstacle tables, sine / cosine unit, step accumulators,
// three-stage obstacle test pipeline and output register.
// ----------------------------------------------------------------------------
module rmoh_dpath
    import rmoh_pkg::*;
#(
    parameter int MAX_SQUARES = MAX_SQUARES_DEF,
    parameter int MAX_CIRCLES = MAX_CIRCLES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic [M_TUSER_W-1:0]       m_tuser,
    input  wire cmd_t                  cmd,
    output sts_t                       sts
);

    localparam int SQ_AW = (MAX_SQUARES > 1) ? $clog2(MAX_SQUARES) : 1;
    localparam int CI_AW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int K_W   = CNT_W + 1;
    localparam int ACC_W = 29;
    localparam int SQ_W  = 48;

    // input fields
    logic [5:0]         in_index;
    logic [31:0]        in_entry;
    logic [ANG_W-1:0]   in_angle;
    assign in_index = s_tdata[5:0];
    assign in_entry = s_tdata[37:6];
    assign in_angle = s_tdata[53:38];

    // configuration
    logic [POS_W-1:0]  viewer_x_reg, viewer_y_reg;
    logic [STEP_W-1:0] max_steps_reg;
    logic [BS_W-1:0]   block_size_reg;
    logic [CNT_W-1:0]  square_count_reg, circle_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            viewer_x_reg     <= VIEWER_RST;
            viewer_y_reg     <= VIEWER_RST;
            max_steps_reg    <= MAX_STEPS_RST;
            block_size_reg   <= BLOCK_SIZE_RST;
            square_count_reg <= COUNT_RST;
            circle_count_reg <= COUNT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_VIEWER_X:     viewer_x_reg     <= cfg_data;
                CFG_VIEWER_Y:     viewer_y_reg     <= cfg_data;
                CFG_MAX_STEPS:    max_steps_reg    <= cfg_data[STEP_W-1:0];
                CFG_BLOCK_SIZE:   block_size_reg   <= cfg_data[BS_W-1:0];
                CFG_SQUARE_COUNT: square_count_reg <= cfg_data[CNT_W-1:0];
                CFG_CIRCLE_COUNT: circle_count_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] ns, nc;
    always_comb begin
        ns = (int'(square_count_reg) > MAX_SQUARES) ? CNT_W'(MAX_SQUARES) : square_count_reg;
        nc = (int'(circle_count_reg) > MAX_CIRCLES) ? CNT_W'(MAX_CIRCLES) : circle_count_reg;
    end

    // obstacle tables
    logic [31:0]      sq_mem [MAX_SQUARES];
    logic [31:0]      ci_mem [MAX_CIRCLES];
    logic [31:0]      sq_rdata_reg, ci_rdata_reg;
    logic [SQ_AW-1:0] sq_raddr;
    logic [CI_AW-1:0] ci_raddr;
    logic             sq_we, ci_we;
    logic [K_W-1:0]   k_reg;
    logic [K_W-1:0]   total;

    assign sq_we = cmd.accept && (s_tuser == OP_WR_SQUARE) && (int'(in_index) < MAX_SQUARES);
    assign ci_we = cmd.accept && (s_tuser == OP_WR_CIRCLE) && (int'(in_index) < MAX_CIRCLES);
    assign total = K_W'(ns) + K_W'(nc);
    assign sq_raddr = SQ_AW'(k_reg);
    assign ci_raddr = CI_AW'(k_reg - K_W'(ns));

    always_ff @(posedge aclk) begin
        if (sq_we) begin
            sq_mem[SQ_AW'(in_index)] <= in_entry;
        end
        sq_rdata_reg <= sq_mem[sq_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ci_we) begin
            ci_mem[CI_AW'(in_index)] <= in_entry;
        end
        ci_rdata_reg <= ci_mem[ci_raddr];
    end

    // sine / cosine, lane 0 cosine, lane 1 sine
    logic [16:0]        z_reg [2];
    logic [16:0]        z2_reg [2];
    logic [16:0]        t_reg [2];
    logic               neg_reg [2];
    logic signed [16:0] trig_reg [2];
    logic [1:0]         trig_ph_reg;

    logic [15:0]        lane_ang [2];
    logic [14:0]        lane_r [2];
    logic [16:0]        mul_a [2];
    logic [16:0]        mul_b [2];
    logic [33:0]        prod [2];
    logic [16:0]        sq_half [2];
    logic [15:0]        sq_sat [2];

    always_comb begin
        lane_ang[0] = in_angle + QUARTER;
        lane_ang[1] = in_angle;
        for (int l = 0; l < 2; l++) begin
            lane_r[l] = lane_ang[l][14] ? (15'(QUARTER) - {1'b0, lane_ang[l][13:0]})
                                        : {1'b0, lane_ang[l][13:0]};
            unique case (trig_ph_reg)
                2'd0: begin mul_a[l] = z_reg[l];  mul_b[l] = z_reg[l];  end
                2'd1: begin mul_a[l] = SIN_C2;    mul_b[l] = z2_reg[l]; end
                2'd2: begin mul_a[l] = t_reg[l];  mul_b[l] = z2_reg[l]; end
                default: begin mul_a[l] = t_reg[l]; mul_b[l] = z_reg[l]; end
            endcase
            prod[l]    = mul_a[l] * mul_b[l];
            sq_half[l] = 17'((18'(prod[l][32:16]) + 18'd1) >> 1);
            sq_sat[l]  = (sq_half[l] > Q15_MAX) ? Q15_MAX[15:0] : sq_half[l][15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            trig_ph_reg <= '0;
            for (int l = 0; l < 2; l++) begin
                z_reg[l]   <= {lane_r[l], 2'b00};
                neg_reg[l] <= lane_ang[l][15];
            end
        end else if (cmd.trig_run) begin
            trig_ph_reg <= trig_ph_reg + 2'd1;
            for (int l = 0; l < 2; l++) begin
                unique case (trig_ph_reg)
                    2'd0: z2_reg[l] <= prod[l][32:16];
                    2'd1: t_reg[l]  <= SIN_C1 - prod[l][32:16];
                    2'd2: t_reg[l]  <= SIN_C3 - prod[l][32:16];
                    default: trig_reg[l] <= neg_reg[l] ? -$signed({1'b0, sq_sat[l]})
                                                       : $signed({1'b0, sq_sat[l]});
                endcase
            end
        end
    end

    // depth accumulators and point
    logic [STEP_W-1:0]        d_reg;
    logic signed [ACC_W-1:0]  acc_x_reg, acc_y_reg;
    logic signed [POS_W-1:0]  px_reg, py_reg;
    logic [33:0]              rad2_reg;
    logic [19:0]              bs_sq;
    logic signed [POS_W-1:0]  px_new, py_new;

    function automatic logic signed [POS_W-1:0] step_coord(
        input logic signed [POS_W-1:0] base,
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] rnd;
        logic signed [25:0]      sum;
        rnd = acc + ACC_W'(64);
        sum = 26'(base) + 26'($signed(rnd[ACC_W-1:7]));
        if (sum[25:23] == 3'b000 || sum[25:23] == 3'b111) begin
            step_coord = sum[POS_W-1:0];
        end else begin
            step_coord = sum[25] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
    endfunction

    assign bs_sq  = block_size_reg * block_size_reg;
    assign px_new = step_coord($signed(viewer_x_reg), acc_x_reg);
    assign py_new = step_coord($signed(viewer_y_reg), acc_y_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            d_reg     <= '0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            px_reg    <= '0;
            py_reg    <= '0;
            rad2_reg  <= {bs_sq, 14'b0};
        end else if (cmd.step_pt) begin
            px_reg <= px_new;
            py_reg <= py_new;
        end else if (cmd.next_step) begin
            d_reg     <= d_reg + STEP_W'(1);
            acc_x_reg <= acc_x_reg + ACC_W'(trig_reg[0]);
            acc_y_reg <= acc_y_reg + ACC_W'(trig_reg[1]);
        end
    end

    // obstacle test pipeline: issue, compare / square, sum and compare
    logic             a_valid_reg, a_circ_reg;
    logic             b_sq_hit_reg, b_circ_reg;
    logic             hit_flag_reg;
    logic [SQ_W-1:0]  dx2_reg, dy2_reg;

    logic [31:0]        entry;
    logic signed [25:0] ex26, ey26, px26, py26, bs26;
    logic               sq_hit;
    logic signed [24:0] dx, dy;
    logic signed [49:0] dx_sq, dy_sq;
    logic [SQ_W:0]      dist2;
    logic               circ_hit;

    always_comb begin
        entry  = a_circ_reg ? ci_rdata_reg : sq_rdata_reg;
        ex26   = 26'($signed({entry[15:0], 8'b0}));
        ey26   = 26'($signed({entry[31:16], 8'b0}));
        px26   = 26'(px_reg);
        py26   = 26'(py_reg);
        bs26   = $signed({8'b0, block_size_reg, 8'b0});
        sq_hit = (px26 >= ex26) && (px26 <= ex26 + bs26)
              && (py26 >= ey26) && (py26 <= ey26 + bs26);
        dx     = 25'(px26 - ex26);
        dy     = 25'(py26 - ey26);
        dx_sq  = dx * dx;
        dy_sq  = dy * dy;
        dist2  = {1'b0, dx2_reg} + {1'b0, dy2_reg};
        circ_hit = b_circ_reg && (dist2 <= (SQ_W+1)'(rad2_reg));
    end

    always_ff @(posedge aclk) begin
        dx2_reg <= dx_sq[SQ_W-1:0];
        dy2_reg <= dy_sq[SQ_W-1:0];
        if (!aresetn) begin
            k_reg        <= '0;
            a_valid_reg  <= 1'b0;
            a_circ_reg   <= 1'b0;
            b_sq_hit_reg <= 1'b0;
            b_circ_reg   <= 1'b0;
            hit_flag_reg <= 1'b0;
        end else begin
            a_valid_reg  <= 1'b0;
            b_sq_hit_reg <= a_valid_reg && !a_circ_reg && sq_hit;
            b_circ_reg   <= a_valid_reg && a_circ_reg;
            if (cmd.step_pt) begin
                k_reg <= '0;
            end else if (cmd.scan_run && (k_reg < total)) begin
                k_reg       <= k_reg + K_W'(1);
                a_valid_reg <= 1'b1;
                a_circ_reg  <= (k_reg >= K_W'(ns));
            end
            if (cmd.load || cmd.step_pt) begin
                hit_flag_reg <= 1'b0;
            end else if (b_sq_hit_reg || circ_hit) begin
                hit_flag_reg <= 1'b1;
            end
        end
    end

    // output register
    logic                     m_tvalid_reg;
    logic                     m_hit_reg;
    logic [STEP_W-1:0]        m_depth_reg;
    logic [POS_W-1:0]         m_x_reg, m_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.result_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.result_load) begin
            m_hit_reg   <= hit_flag_reg;
            m_depth_reg <= hit_flag_reg ? d_reg : '0;
            m_x_reg     <= px_reg;
            m_y_reg     <= py_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, m_y_reg, m_x_reg, m_depth_reg};
    assign m_tuser  = m_hit_reg;

    always_comb begin
        sts.trig_done  = (trig_ph_reg == TRIG_LAST);
        sts.scan_done  = (k_reg >= total);
        sts.pipe_busy  = a_valid_reg || b_sq_hit_reg || b_circ_reg;
        sts.hit        = hit_flag_reg;
        sts.last_step  = ((STEP_W+1)'(d_reg) + (STEP_W+1)'(1)) == (STEP_W+1)'(max_steps_reg);
        sts.zero_steps = (max_steps_reg == '0);
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    a_pipe_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_circ_reg || b_sq_hit_reg) |-> $past(a_valid_reg))
        else $error("test stage without issue");

    a_hit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(hit_flag_reg) |-> $past(b_sq_hit_reg || b_circ_reg))
        else $error("hit flag set without a test result");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrote a pending transfer");

endmodule : rmoh_dpath
`default_nettype wire

@@ src/ray_march_obstacle_hit_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_march_obstacle_hit_top
// 2D ray marcher: casts a ray from the viewer against tables of squares and
// circles and reports the first obstacle hit.
// ----------------------------------------------------------------------------
// Input transfers carry an opcode in s_tuser: write square entry, write circle
// entry or cast ray. Writes return nothing; opcode 3 is dropped. A cast
// computes cosine and sine, then walks depth steps 0..max_steps-1. Each step
// forms the point and scans the square_count + circle_count table entries
// (counts limited to the table depth) one entry per cycle through a single
// read port per table, followed by a two-stage drain of the compare pipeline.
// Only one item is in work at a time; the next input is taken while a result
// still waits in the output register. Configuration is written at any time
// through cfg_*, always ready, and must only change while the block is idle.
// ----------------------------------------------------------------------------
module ray_march_obstacle_hit_top
    import rmoh_pkg::*;
#(
    parameter int MAX_SQUARES = MAX_SQUARES_DEF,
    parameter int MAX_CIRCLES = MAX_CIRCLES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // entry_index[5:0], entry_x[21:6], entry_y[37:22], ray_angle[53:38], zero pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // opcode[1:0]
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // hit_depth[11:0], end_x[35:12], end_y[59:36], zero pad
    output logic [M_TDATA_W-1:0]       m_tdata,
    // hit[0]
    output logic [M_TUSER_W-1:0]       m_tuser,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // register writes are always accepted
    assign cfg_ready = 1'b1;

    // sequencer
    rmoh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tables, trig, stepping, compare pipeline, output register
    rmoh_dpath #(
        .MAX_SQUARES (MAX_SQUARES),
        .MAX_CIRCLES (MAX_CIRCLES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule : ray_march_obstacle_hit_top
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2D ray marcher. Square and circle table loads
// and ray casts go in over the input stream. A scoreboard class predicts each
// cast result from its own march and table copy, and compares every result
// transfer field by field. The bench steps through several register settings,
// extremes included, and varies the stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
    import rmoh_pkg::*;

    // ------------------------------------------------------------------------
    // cast predictor and expected-result store
    // ------------------------------------------------------------------------
    class cast_scoreboard;
        typedef struct {
            logic                     hit;
            logic [STEP_W-1:0]        depth;
            logic signed [POS_W-1:0]  px;
            logic signed [POS_W-1:0]  py;
        } cast_res_t;

        cast_res_t                  pending_casts[$];
        logic signed [COORD_W-1:0]  sq_x[MAX_SQUARES_DEF], sq_y[MAX_SQUARES_DEF];
        logic signed [COORD_W-1:0]  ci_x[MAX_CIRCLES_DEF], ci_y[MAX_CIRCLES_DEF];
        logic signed [POS_W-1:0]    view_x, view_y;
        logic [STEP_W-1:0]          step_limit;
        logic [BS_W-1:0]            side;
        logic [CNT_W-1:0]           n_sq, n_ci;
        int                         errors, casts, hits, writes;

        function new();
            view_x = '0;
            view_y = '0;
            step_limit = MAX_STEPS_RST;
            side = BLOCK_SIZE_RST;
            n_sq = COUNT_RST;
            n_ci = COUNT_RST;
            errors = 0;
            casts = 0;
            hits = 0;
            writes = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_VIEWER_X:     view_x = val[POS_W-1:0];
                CFG_VIEWER_Y:     view_y = val[POS_W-1:0];
                CFG_MAX_STEPS:    step_limit = val[STEP_W-1:0];
                CFG_BLOCK_SIZE:   side = val[BS_W-1:0];
                CFG_SQUARE_COUNT: n_sq = val[CNT_W-1:0];
                CFG_CIRCLE_COUNT: n_ci = val[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // quarter-wave polynomial, q1.15, r in 0..16384
        function longint quarter_wave(longint r);
            longint z, z2, t, s;
            z = r << 2;
            z2 = (z * z) >>> 16;
            t = 42334 - ((5223 * z2) >>> 16);
            t = 102944 - ((t * z2) >>> 16);
            s = (t * z) >>> 16;
            s = (s + 1) >>> 1;
            return (s > 32767) ? 32767 : s;
        endfunction

        function longint sine_q15(logic [ANG_W-1:0] a);
            longint v;
            v = quarter_wave(a[14] ? 16384 - longint'(a[13:0]) : longint'(a[13:0]));
            return a[15] ? -v : v;
        endfunction

        function longint clamp_pos(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        function bit blocked(longint px, longint py);
            longint bs, rad, sx, sy, dx, dy;
            int ns, nc;
            bs = longint'(side);
            rad = bs * 128;
            ns = (n_sq > MAX_SQUARES_DEF) ? MAX_SQUARES_DEF : n_sq;
            nc = (n_ci > MAX_CIRCLES_DEF) ? MAX_CIRCLES_DEF : n_ci;
            for (int i = 0; i < ns; i++) begin
                sx = longint'(sq_x[i]) * 256;
                sy = longint'(sq_y[i]) * 256;
                if (px >= sx && px <= sx + bs * 256 && py >= sy && py <= sy + bs * 256)
                    return 1'b1;
            end
            for (int i = 0; i < nc; i++) begin
                dx = px - longint'(ci_x[i]) * 256;
                dy = py - longint'(ci_y[i]) * 256;
                if (dx * dx + dy * dy <= rad * rad)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // accepted input transfer: update tables or queue the cast outcome
        function void note_item(logic [1:0] op, logic [5:0] idx, logic signed [15:0] ex,
                                logic signed [15:0] ey, logic [ANG_W-1:0] ang);
            cast_res_t r;
            longint c, s, px, py;
            if (op == OP_WR_SQUARE) begin
                sq_x[idx] = ex;
                sq_y[idx] = ey;
                writes++;
            end else if (op == OP_WR_CIRCLE) begin
                ci_x[idx] = ex;
                ci_y[idx] = ey;
                writes++;
            end else if (op == OP_CAST) begin
                c = sine_q15(ang + QUARTER);
                s = sine_q15(ang);
                px = 0;
                py = 0;
                r.hit = 1'b0;
                r.depth = '0;
                for (longint d = 0; d < step_limit; d++) begin
                    // floor of (d*trig + 64) / 128
                    px = clamp_pos(longint'(view_x) + ((d * c + 64) >>> 7));
                    py = clamp_pos(longint'(view_y) + ((d * s + 64) >>> 7));
                    if (blocked(px, py)) begin
                        r.hit = 1'b1;
                        r.depth = d[STEP_W-1:0];
                        break;
                    end
                end
                r.px = px[POS_W-1:0];
                r.py = py[POS_W-1:0];
                pending_casts.push_back(r);
                casts++;
                if (r.hit) hits++;
            end
        endfunction

        function void check_result(logic hit, logic [STEP_W-1:0] depth,
                                   logic [POS_W-1:0] px, logic [POS_W-1:0] py);
            cast_res_t e;
            if (pending_casts.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transfer: hit=%0d depth=%0d x=%0h y=%0h",
                             hit, depth, px, py);
                return;
            end
            e = pending_casts.pop_front();
            if (hit !== e.hit || depth !== e.depth || px !== e.px || py !== e.py) begin
                errors++;
                if (errors <= 10)
                    $display("cast mismatch: exp hit=%0d depth=%0d x=%0h y=%0h, got hit=%0d depth=%0d x=%0h y=%0h",
                             e.hit, e.depth, e.px, e.py, hit, depth, px, py);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, block
    // ------------------------------------------------------------------------
    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    always #5 aclk = ~aclk;

    ray_march_obstacle_hit_top u_top (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    cast_scoreboard sb = new();

    int  items_sent = 0;
    int  send_idle_pct = 6;     // chance per cycle the sender holds back
    int  recv_idle_pct = 68;    // chance per cycle the receiver stalls
    int  hold_cycles = 0;       // long receiver hold-off, counted down below
    bit  sq_loaded[MAX_SQUARES_DEF];
    bit  ci_loaded[MAX_CIRCLES_DEF];
    longint cycle_count = 0;

    // result side: check every transfer, stall at random or for a long stretch
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser[0], m_tdata[11:0], m_tdata[35:12], m_tdata[59:36]);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 6000000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_item(logic [1:0] op, logic [5:0] idx, logic [15:0] ex,
                             logic [15:0] ey, logic [15:0] ang);
        // idle gaps scale with the current sender setting
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, ang, ey, ex, idx};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, idx, ex, ey, ang);
        items_sent++;
        if (op == OP_WR_SQUARE) sq_loaded[idx] = 1'b1;
        if (op == OP_WR_CIRCLE) ci_loaded[idx] = 1'b1;
        // stall pattern follows progress through the run
        if (items_sent == 190) begin
            send_idle_pct = 68;
            recv_idle_pct = 6;
        end else if (items_sent == 380) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        // let the block fill up while the receiver holds off
        if (items_sent == 250)
            hold_cycles = 3000;
    endtask

    // wait for all casts to come back, then let a trailing write settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending_casts.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    // make sure every slot that will be in use holds a written entry
    task automatic load_slots(int nsq, int nci);
        for (int i = 0; i < nsq && i < MAX_SQUARES_DEF; i++)
            if (!sq_loaded[i])
                send_item(OP_WR_SQUARE, i, $urandom_range(120) - 60, $urandom_range(120) - 60, 0);
        for (int i = 0; i < nci && i < MAX_CIRCLES_DEF; i++)
            if (!ci_loaded[i])
                send_item(OP_WR_CIRCLE, i, $urandom_range(120) - 60, $urandom_range(120) - 60, 0);
        drain();
    endtask

    task automatic configure(logic [23:0] vx, logic [23:0] vy, logic [11:0] ms,
                             logic [9:0] bs, logic [6:0] nsq, logic [6:0] nci);
        load_slots(nsq, nci);
        cfg_write(CFG_VIEWER_X, vx);
        cfg_write(CFG_VIEWER_Y, vy);
        cfg_write(CFG_MAX_STEPS, ms);
        cfg_write(CFG_BLOCK_SIZE, bs);
        cfg_write(CFG_SQUARE_COUNT, nsq);
        cfg_write(CFG_CIRCLE_COUNT, nci);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int pick;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: empty tables, casts run to the full step count
        send_item(OP_CAST, 0, 0, 0, 16'h0000);
        send_item(OP_CAST, 0, 0, 0, 16'hFFFF);
        send_item(2'd3, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF);   // unused opcode, dropped
        send_item(OP_CAST, 0, 0, 0, 16'h4000);
        drain();

        // zero steps and zero block size
        send_item(OP_WR_SQUARE, 0, 16'sd0, 16'sd0, 0);
        send_item(OP_WR_CIRCLE, 0, 16'sd2, 16'sd0, 0);
        configure(24'd0, 24'd0, 12'd0, 10'd0, 7'd1, 7'd1);
        send_item(OP_CAST, 0, 0, 0, 16'h2000);
        drain();
        cfg_write(CFG_MAX_STEPS, 12'd5);
        send_item(OP_CAST, 0, 0, 0, 16'h0000);    // point square at the viewer
        send_item(OP_CAST, 0, 0, 0, 16'h8000);
        drain();

        // saturation at both corners, longest march
        configure(24'h7FFFFF, 24'h7FFFFF, 12'd4095, 10'd1, 7'd0, 7'd0);
        send_item(OP_CAST, 0, 0, 0, 16'h2000);
        drain();
        configure(24'h800000, 24'h800000, 12'd4095, 10'd1, 7'd0, 7'd0);
        send_item(OP_CAST, 0, 0, 0, 16'hA000);
        drain();

        // field extremes in the tables, counts above the table depth
        send_item(OP_WR_SQUARE, 6'h3F, 16'h8000, 16'h7FFF, 0);
        send_item(OP_WR_CIRCLE, 6'h3F, 16'h7FFF, 16'h8000, 0);
        configure(24'h000080, 24'hFFFF80, 12'd3, 10'd1023, 7'd127, 7'd127);
        send_item(OP_CAST, 0, 0, 0, 16'hC000);
        send_item(OP_CAST, 0, 0, 0, 16'h5555);
        drain();
        configure(24'h000000, 24'h000000, 12'd3, 10'd1023, 7'd64, 7'd64);
        send_item(OP_CAST, 0, 0, 0, 16'hAAAA);
        drain();

        // random phases: obstacles close to the viewer so that rays hit
        while (items_sent < 580) begin
            configure(($urandom_range(100) - 50) * 256 + $urandom_range(255),
                      ($urandom_range(100) - 50) * 256 + $urandom_range(255),
                      $urandom_range(1, 60), $urandom_range(1, 30),
                      $urandom_range(0, 4), $urandom_range(0, 4));
            repeat ($urandom_range(8, 30)) begin
                pick = $urandom_range(99);
                if (pick < 20)
                    send_item(OP_WR_SQUARE, $urandom_range(63), $urandom_range(120) - 60,
                              $urandom_range(120) - 60, $urandom);
                else if (pick < 30)
                    send_item(OP_WR_CIRCLE, $urandom_range(63), $urandom_range(120) - 60,
                              $urandom_range(120) - 60, $urandom);
                else if (pick < 35)
                    // full-range coordinates, rarely reached
                    send_item($urandom_range(1), $urandom_range(63), $urandom, $urandom, $urandom);
                else if (pick < 38)
                    send_item(2'd3, $urandom, $urandom, $urandom, $urandom);
                else
                    send_item(OP_CAST, $urandom, $urandom, $urandom, $urandom);
            end
            drain();
        end

        $display("covered %0d items: %0d casts (%0d hits), %0d table loads",
                 items_sent, sb.casts, sb.hits, sb.writes);
        if (sb.errors == 0 && sb.pending_casts.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("mismatches: %0d, casts still pending: %0d",
                     sb.errors, sb.pending_casts.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/rmoh_pkg.sv
src/rmoh_ctrl.sv
src/rmoh_dpath.sv
src/ray_march_obstacle_hit_top.sv
tb/tb_top.sv
